### hdl/abi_pkg.sv
// Shared types and constants for the basic integer ALU.
// Holds the operation codes, the front-to-back item record and the divider step.
`timescale 1ns / 1ps
`default_nettype none
package abi_pkg;
	localparam int W = 32;

	localparam logic [4:0] OP_ADD  = 5'd0;
	localparam logic [4:0] OP_SUB  = 5'd1;
	localparam logic [4:0] OP_MUL  = 5'd2;
	localparam logic [4:0] OP_AND  = 5'd3;
	localparam logic [4:0] OP_OR   = 5'd4;
	localparam logic [4:0] OP_EOR  = 5'd5;
	localparam logic [4:0] OP_DIV  = 5'd6;
	localparam logic [4:0] OP_IDIV = 5'd7;
	localparam logic [4:0] OP_MOD  = 5'd8;
	localparam logic [4:0] OP_EQ   = 5'd9;
	localparam logic [4:0] OP_NEQ  = 5'd10;
	localparam logic [4:0] OP_LT   = 5'd11;
	localparam logic [4:0] OP_LTE  = 5'd12;
	localparam logic [4:0] OP_GT   = 5'd13;
	localparam logic [4:0] OP_GTE  = 5'd14;
	localparam logic [4:0] OP_NEG  = 5'd15;
	localparam logic [4:0] OP_NOT  = 5'd16;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DIV0  = 2'd1;
	localparam logic [1:0] ST_INEXACT = 2'd2;

	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_SIMPLE,
		CLS_DIV
	} cls_t;

	// one classified operation, as handed from front to back
	typedef struct packed {
		logic [4:0]   mode;
		cls_t         cls;
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] mag_a;
		logic [W-1:0] mag_b;
		logic         sa;
		logic         sb;
	} op_t;

	// one stage of the back pipeline
	typedef struct packed {
		logic [4:0]   mode;
		cls_t         cls;
		logic [W-1:0] res;
		logic [W-1:0] quo;
		logic [W-1:0] rem;
		logic [W-1:0] den;
		logic         sa;
		logic         sb;
	} stg_t;

	// one restoring division step: bring down the next dividend bit
	function automatic stg_t div_step(input stg_t s);
		stg_t         r;
		logic [W:0]   trial;
		logic [W:0]   diff;
		r = s;
		trial = {s.rem, s.quo[W-1]};
		diff = trial - {1'b0, s.den};
		if (!diff[W]) begin
			r.rem = diff[W-1:0];
			r.quo = {s.quo[W-2:0], 1'b1};
		end else begin
			r.rem = trial[W-1:0];
			r.quo = {s.quo[W-2:0], 1'b0};
		end
		return r;
	endfunction
endpackage
`default_nettype wire

### hdl/abi_front.sv
// Front end: registers an incoming beat and classifies it for the back end.
// Depends on abi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module abi_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [4:0]         mode,
	input  wire logic [31:0]        left_operand,
	input  wire logic [31:0]        right_operand,
	output logic                    op_valid,
	input  wire logic               op_ready,
	output abi_pkg::op_t            op
);
	import abi_pkg::*;

	logic v_s1;
	op_t  op_s1;
	cls_t cls;

	always_comb begin
		unique case (mode)
			OP_DIV, OP_IDIV, OP_MOD: cls = CLS_DIV;
			OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_EOR, OP_EQ, OP_NEQ,
			OP_LT, OP_LTE, OP_GT, OP_GTE, OP_NEG, OP_NOT: cls = CLS_SIMPLE;
			default: cls = CLS_NONE;
		endcase
	end

	assign in_ready = !v_s1 || op_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1.mode  <= mode;
			op_s1.cls   <= cls;
			op_s1.a     <= left_operand;
			op_s1.b     <= right_operand;
			op_s1.sa    <= left_operand[31];
			op_s1.sb    <= right_operand[31];
			op_s1.mag_a <= left_operand[31] ? (32'd0 - left_operand) : left_operand;
			op_s1.mag_b <= right_operand[31] ? (32'd0 - right_operand) : right_operand;
		end
	end

	assign op_valid = v_s1;
	assign op = op_s1;
endmodule
`default_nettype wire

### hdl/abi_fifo.sv
// Two-entry queue between the front and back ends.
// Depends on abi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module abi_fifo (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push_valid,
	output logic          push_ready,
	input  abi_pkg::op_t  push_op,
	output logic          pop_valid,
	input  wire logic     pop_ready,
	output abi_pkg::op_t  pop_op
);
	import abi_pkg::*;

	op_t        mem [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign do_push = push_valid && push_ready;
	assign do_pop  = pop_valid && pop_ready;
	assign pop_op = mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) wptr_q <= !wptr_q;
			if (do_pop) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem[wptr_q] <= push_op;
	end
endmodule
`default_nettype wire

### hdl/abi_back.sv
// Back end: execution pipeline that computes the simple operations at its load stage and a bit-per-stage divider.
// Depends on abi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module abi_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         op_valid,
	output logic              op_ready,
	input  abi_pkg::op_t      op,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [31:0]       result_value,
	output logic [1:0]        status
);
	import abi_pkg::*;

	localparam int NS = W + 1;

	logic        en;
	logic [NS-1:0] v_q;
	stg_t        stg_q [NS];
	stg_t        ld;
	logic [31:0] simple;
	logic        out_v_q;
	logic [31:0] res_q;
	logic [1:0]  st_q;
	stg_t        fin;
	logic [31:0] qs;
	logic [31:0] rs;
	logic [31:0] fres;
	logic [1:0]  fst;

	// the whole pipe advances together; hold while the output beat waits
	assign en = !out_v_q || out_ready;
	assign op_ready = en;

	always_comb begin
		case (op.mode)
			OP_ADD:  simple = op.a + op.b;
			OP_SUB:  simple = op.a - op.b;
			OP_MUL:  simple = op.a * op.b;
			OP_AND:  simple = op.a & op.b;
			OP_OR:   simple = op.a | op.b;
			OP_EOR:  simple = op.a ^ op.b;
			OP_EQ:   simple = {32{op.a == op.b}};
			OP_NEQ:  simple = {32{op.a != op.b}};
			OP_LT:   simple = {32{$signed(op.a) <  $signed(op.b)}};
			OP_LTE:  simple = {32{$signed(op.a) <= $signed(op.b)}};
			OP_GT:   simple = {32{$signed(op.a) >  $signed(op.b)}};
			OP_GTE:  simple = {32{$signed(op.a) >= $signed(op.b)}};
			OP_NEG:  simple = 32'd0 - op.a;
			OP_NOT:  simple = ~op.a;
			default: simple = 32'd0;
		endcase
		ld.mode = op.mode;
		ld.cls  = op.cls;
		ld.res  = simple;
		ld.quo  = op.mag_a;
		ld.rem  = 32'd0;
		ld.den  = op.mag_b;
		ld.sa   = op.sa;
		ld.sb   = op.sb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NS-2:0], op_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_q[0] <= ld;
			for (int i = 1; i < NS; i++) begin
				stg_q[i] <= div_step(stg_q[i-1]);
			end
		end
	end

	// sign fix and status on the last stage
	always_comb begin
		fin = stg_q[NS-1];
		qs = (fin.sa ^ fin.sb) ? (32'd0 - fin.quo) : fin.quo;
		rs = fin.sa ? (32'd0 - fin.rem) : fin.rem;
		fres = 32'd0;
		fst = ST_OK;
		case (fin.cls)
			CLS_SIMPLE: fres = fin.res;
			CLS_DIV: begin
				if (fin.den == 32'd0) begin
					fst = ST_DIV0;
				end else if (fin.mode == OP_MOD) begin
					fres = rs;
				end else if (fin.mode == OP_DIV && fin.rem != 32'd0) begin
					fst = ST_INEXACT;
				end else begin
					fres = qs;
				end
			end
			default: fres = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_q[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= fres;
			st_q  <= fst;
		end
	end

	assign out_valid = out_v_q;
	assign result_value = res_q;
	assign status = st_q;
endmodule
`default_nettype wire

### hdl/basic_integer_alu.sv
// Basic integer ALU top level: front end, two-entry queue, execution back end.
// The divider resolves one quotient bit per stage.
// Throughput: one operation per cycle while the output is not stalled.
// Reset: arst_n clears all valid flags asynchronously; payload is not reset.
// Depends on abi_pkg, abi_front, abi_fifo, abi_back.
`timescale 1ns / 1ps
`default_nettype none
module basic_integer_alu (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [4:0]  mode,
	input  wire logic [31:0] left_operand,
	input  wire logic [31:0] right_operand,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      result_value,
	output logic [1:0]       status
);
	import abi_pkg::*;

	logic f_valid;
	logic f_ready;
	op_t  f_op;
	logic b_valid;
	logic b_ready;
	op_t  b_op;

	abi_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .left_operand(left_operand), .right_operand(right_operand),
		.op_valid(f_valid), .op_ready(f_ready), .op(f_op)
	);

	abi_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push_valid(f_valid), .push_ready(f_ready), .push_op(f_op),
		.pop_valid(b_valid), .pop_ready(b_ready), .pop_op(b_op)
	);

	abi_back u_back (
		.clk(clk), .arst_n(arst_n),
		.op_valid(b_valid), .op_ready(b_ready), .op(b_op),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_value(result_value), .status(status)
	);

`ifndef NO_ASSERTIONS
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != 2'd3))
		else $error("illegal status code");
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (result_value == 32'd0))
		else $error("nonzero result with error status");
`endif
endmodule
`default_nettype wire
